// ----- hw/rtl/cfi_pkg.sv -----
`timescale 1ns / 1ps

package cfi_pkg;

    // Field widths of the bus transactions.
    localparam int IDX_W     = 10;
    localparam int DATA_W    = 32;
    localparam int S_TDATA_W = 48;

    // Command bytes, taken from bits 7..0 of a written word.
    localparam logic [7:0] CMD_READ_ARRAY   = 8'hFF;
    localparam logic [7:0] CMD_READ_STATUS  = 8'h70;
    localparam logic [7:0] CMD_CLEAR_STATUS = 8'h50;
    localparam logic [7:0] CMD_PROGRAM      = 8'h40;
    localparam logic [7:0] CMD_ERASE_SETUP  = 8'h20;
    localparam logic [7:0] CMD_ERASE_OK     = 8'hD0;

    // Status register layout.
    localparam logic [DATA_W-1:0] SR_READY    = 32'h0000_0080;
    localparam logic [DATA_W-1:0] SR_ERR_MASK = 32'h0000_0038;

    // Read and command modes of the device.
    localparam logic [1:0] MODE_ARRAY  = 2'd0;
    localparam logic [1:0] MODE_STATUS = 2'd1;
    localparam logic [1:0] MODE_PROG   = 2'd2;
    localparam logic [1:0] MODE_ERASE  = 2'd3;

    // Error bits: erase error (SR.5), program error (SR.4), voltage error (SR.3).
    localparam logic [2:0] ERR_ERASE = 3'b100;
    localparam logic [2:0] ERR_PROG  = 3'b010;

endpackage

// ----- hw/rtl/cfi_flash_command_interface.sv -----
`timescale 1ns / 1ps
// The result of a read or a write is registered from ST_EXEC once the output register is free.
// A transaction is accepted only in ST_IDLE, so none is taken while the last is still in progress.
// An erase confirm keeps the input stalled through the sector quotient step, the setup step
// and up to SECTOR_WORDS word writes of the sector sweep on the single write port.
// Reset (aresetn low, synchronous) clears mode and error bits, then a clearing pass writes
// all ones to the array, one word a cycle over all ARRAY_WORDS words, with s_tready held low.

module cfi_flash_command_interface #(
    parameter int ARRAY_WORDS  = 1024,
    parameter int SECTOR_WORDS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata fields from bit 0: word_index[9:0], write_data[41:10], zero pad[47:42].
    input  logic [cfi_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser fields from bit 0: req_type (0 read, 1 write).
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata fields from bit 0: read_data[31:0].
    output logic [cfi_pkg::DATA_W-1:0]     m_tdata,
    // m_tuser fields from bit 0: was_read.
    output logic                           m_tuser
);

    localparam int AW  = $clog2(ARRAY_WORDS);
    localparam int SW  = $clog2(SECTOR_WORDS + 1);
    localparam int DW  = AW + SW;
    localparam int RED_STEPS = (ARRAY_WORDS >= 2 ** cfi_pkg::IDX_W) ? 0 :
                               cfi_pkg::IDX_W - AW + 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(ARRAY_WORDS - 1);

    // Rounded-up reciprocal of the sector size, exact for every address below 2**AW.
    localparam int RECIP_SH = AW + $clog2(SECTOR_WORDS);
    localparam int RW       = AW + 2;
    localparam int PW       = 2 * AW + 2;
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << RECIP_SH) + 64'(SECTOR_WORDS) - 64'd1) / 64'(SECTOR_WORDS));

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_ESETUP = 3'd4;
    localparam logic [2:0] ST_ERASE  = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [1:0]                 mode_reg, mode_next;
    logic [2:0]                 err_reg, err_next;
    logic                       req_type_reg;
    logic [AW-1:0]              idx_reg;
    logic [cfi_pkg::DATA_W-1:0] data_reg;
    logic [AW-1:0]              sweep_reg, sweep_next;
    logic [AW-1:0]              last_reg, last_next;
    logic [AW-1:0]              quo_reg, quo_next;
    logic                       m_valid_reg, m_valid_next;
    logic [cfi_pkg::DATA_W-1:0] m_data_reg, m_data_next;
    logic                       m_user_reg, m_user_next;

    logic [cfi_pkg::DATA_W-1:0] mem [ARRAY_WORDS];
    logic [cfi_pkg::DATA_W-1:0] rdata_reg;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [cfi_pkg::DATA_W-1:0] mem_wdata;

    logic [cfi_pkg::IDX_W-1:0]  red_idx;
    logic [AW-1:0]              in_idx;
    logic                       in_accept;
    logic                       out_free;
    logic [7:0]                 cmd;
    logic [cfi_pkg::DATA_W-1:0] status_word;
    logic [PW-1:0]              quo_prod;
    logic [AW-1:0]              erase_base;
    logic [DW-1:0]              erase_top;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cmd       = data_reg[7:0];
    assign status_word = cfi_pkg::SR_READY |
                         ((cfi_pkg::DATA_W'(err_reg) << 3) & cfi_pkg::SR_ERR_MASK);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // Reduce the incoming word address into the array by shifted subtractions.
    always_comb begin
        red_idx = s_tdata[cfi_pkg::IDX_W-1:0];
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (32'(red_idx) >= (ARRAY_WORDS << k)) begin
                red_idx = red_idx - cfi_pkg::IDX_W'(ARRAY_WORDS << k);
            end
        end
        in_idx = AW'(red_idx);
    end

    // Sector quotient by reciprocal multiplication, then the sector bounds from it.
    assign quo_prod   = PW'(idx_reg) * PW'(RECIP);
    assign erase_base = AW'(DW'(quo_reg) * DW'(SECTOR_WORDS));
    assign erase_top  = DW'(erase_base) + DW'(SECTOR_WORDS - 1);

    // Array memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            rdata_reg <= mem[in_idx];
        end
    end

    // Sequencer: clearing pass, decode, read-modify-write, sector quotient and sector sweeps.
    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        err_next     = err_reg;
        sweep_next   = sweep_reg;
        last_next    = last_reg;
        quo_next     = quo_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        mem_we       = 1'b0;
        mem_waddr    = sweep_reg;
        mem_wdata    = '1;

        unique case (state_reg)
            ST_INIT: begin
                mem_we = 1'b1;
                if (sweep_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The transaction completes once the output register can take its result.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_user_next  = !req_type_reg;
                    state_next   = ST_IDLE;
                    if (!req_type_reg) begin
                        m_data_next = (mode_reg == cfi_pkg::MODE_ARRAY) ? rdata_reg
                                                                         : status_word;
                    end else begin
                        unique case (mode_reg)
                            cfi_pkg::MODE_PROG: begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_reg;
                                mem_wdata = rdata_reg & data_reg;
                                mode_next = cfi_pkg::MODE_STATUS;
                            end
                            cfi_pkg::MODE_ERASE: begin
                                mode_next = cfi_pkg::MODE_STATUS;
                                if (cmd == cfi_pkg::CMD_ERASE_OK) begin
                                    state_next = ST_DIV;
                                end else begin
                                    err_next = err_reg | cfi_pkg::ERR_ERASE |
                                               cfi_pkg::ERR_PROG;
                                end
                            end
                            default: begin
                                priority if (cmd == cfi_pkg::CMD_READ_ARRAY) begin
                                    mode_next = cfi_pkg::MODE_ARRAY;
                                end else if (cmd == cfi_pkg::CMD_READ_STATUS) begin
                                    mode_next = cfi_pkg::MODE_STATUS;
                                end else if (cmd == cfi_pkg::CMD_CLEAR_STATUS) begin
                                    err_next = '0;
                                end else if (cmd == cfi_pkg::CMD_PROGRAM) begin
                                    mode_next = cfi_pkg::MODE_PROG;
                                end else if (cmd == cfi_pkg::CMD_ERASE_SETUP) begin
                                    mode_next = cfi_pkg::MODE_ERASE;
                                end else begin
                                    // Unknown command bytes leave the mode as it is.
                                    mode_next = mode_reg;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_DIV: begin
                // Sector number of the confirmed address.
                quo_next   = AW'(quo_prod >> RECIP_SH);
                state_next = ST_ESETUP;
            end
            ST_ESETUP: begin
                // A sector that runs past the end of the array stops at the array's last word.
                sweep_next = erase_base;
                if (erase_top > DW'(ARRAY_WORDS - 1)) begin
                    last_next = LAST_WORD;
                end else begin
                    last_next = erase_top[AW-1:0];
                end
                state_next = ST_ERASE;
            end
            ST_ERASE: begin
                mem_we = 1'b1;
                if (sweep_reg == last_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            mode_reg    <= cfi_pkg::MODE_ARRAY;
            err_reg     <= '0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            err_reg     <= err_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            req_type_reg <= s_tuser;
            idx_reg      <= in_idx;
            data_reg     <= s_tdata[cfi_pkg::IDX_W +: cfi_pkg::DATA_W];
        end
        last_reg   <= last_next;
        quo_reg    <= quo_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

endmodule

// ----- hw/rtl/cfi_checker.sv -----
`timescale 1ns / 1ps

module cfi_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [cfi_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cfi_pkg::DATA_W-1:0]     m_tdata,
    input logic                           m_tuser
);

    // Reset leaves the block with no result pending and the input closed for the clearing pass.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("input open or result pending right after reset");

    // A write transaction always answers with zero data.
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("write result carries nonzero data");

    // Each transaction closes the input once it is accepted, so no two are taken back to back.
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in two consecutive cycles");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind cfi_flash_command_interface cfi_checker u_cfi_checker (.*);
